// File: src/slist_pkg.sv
`timescale 1ns / 1ps

package slist_pkg;

	typedef enum logic [2:0] {
		ACT_PUSH   = 3'd0,
		ACT_POP    = 3'd1,
		ACT_READ   = 3'd2,
		ACT_INSERT = 3'd3,
		ACT_DELETE = 3'd4,
		ACT_REMOVE = 3'd5,
		ACT_FIND   = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [6:0]  position;
		logic [31:0] item_value;
	} req_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic [5:0]  result_position;
		logic [6:0]  entry_count;
		logic [1:0]  status;
	} rsp_t;

	// per-cell update: keep, take the broadcast word, take from the cell below or above
	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_LOAD = 2'd1,
		OP_UP   = 2'd2,
		OP_DOWN = 2'd3
	} cell_op_t;

	typedef enum logic [1:0] {
		UPD_NONE   = 2'd0,
		UPD_INSERT = 2'd1,
		UPD_DELETE = 2'd2
	} upd_kind_t;

endpackage

// File: src/slist_cell.sv
`timescale 1ns / 1ps

module slist_cell import slist_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int PW         = 7,
	parameter int INDEX      = 0
) (
	input  logic                  clk,
	input  logic                  cmp_en,
	input  logic [DATA_WIDTH-1:0] key,
	input  logic [PW-1:0]         count,
	input  logic [PW-1:0]         rd_pos,
	input  cell_op_t              op,
	input  logic [DATA_WIDTH-1:0] lo_data,
	input  logic [DATA_WIDTH-1:0] hi_data,
	output logic [DATA_WIDTH-1:0] data,
	output logic                  match,
	output logic [DATA_WIDTH-1:0] rd_word
);

	localparam logic [PW-1:0] MY_IDX = PW'(INDEX);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  match_q;
	logic [DATA_WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: data_q <= key;
			OP_UP:   data_q <= lo_data;
			OP_DOWN: data_q <= hi_data;
			default: data_q <= data_q;
		endcase
		if (cmp_en) begin
			match_q <= (MY_IDX < count) && (data_q == key);
			rd_q    <= (MY_IDX == rd_pos) ? data_q : '0;
		end
	end

	assign data    = data_q;
	assign match   = match_q;
	assign rd_word = rd_q;

endmodule

// File: src/shifting_ordered_list.sv
`timescale 1ns / 1ps

// Ordered list of up to DEPTH words held in a row of cells, one word per cell.
// Each request passes through the accepting edge, a compare cycle in which
// every cell checks its word against the request word and the read position, a
// resolve cycle that picks the first match and the read word and decides the
// outcome, and an update cycle in which the cells shift or load in one step
// while done is high with the result word. busy stays high from the accepting
// edge through the done cycle; a new request is taken only after that.
// done is high for that one cycle only; the receiver must take it then.

module shifting_ordered_list import slist_pkg::*; #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t result
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int PW    = (CNT_W > 7) ? CNT_W : 7;
	localparam logic [PW-1:0] FULL_CNT = PW'(DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_RES,
		S_UPD
	} state_t;

	state_t                state_q;
	req_t                  req_q;
	logic [PW-1:0]         count_q;
	logic [PW-1:0]         tgt_q;
	upd_kind_t             kind_q;
	rsp_t                  rsp_q;
	logic                  done_q;

	logic [DATA_WIDTH-1:0] key;
	logic [PW-1:0]         pos;
	logic [PW-1:0]         rd_pos;
	logic [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];
	logic [DEPTH-1:0]      cell_match;
	cell_op_t              cell_op   [DEPTH];

	logic                  hit;
	logic [IDX_W-1:0]      hit_idx;
	logic [DATA_WIDTH-1:0] rd_any;
	logic [PW-1:0]         hit_pos;

	logic [PW-1:0]         nxt_count;
	logic [PW-1:0]         nxt_tgt;
	upd_kind_t             nxt_kind;
	rsp_t                  nxt_rsp;

	assign key    = DATA_WIDTH'(req_q.item_value);
	assign pos    = PW'(req_q.position);
	assign rd_pos = (action_t'(req_q.action) == ACT_POP) ? (count_q - PW'(1)) : pos;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			localparam logic [PW-1:0] G_IDX = PW'(g);
			logic [DATA_WIDTH-1:0] lo;
			logic [DATA_WIDTH-1:0] hi;

			if (g == 0) begin : g_lo0
				assign lo = '0;
			end else begin : g_lo
				assign lo = cell_data[g-1];
			end
			if (g == DEPTH - 1) begin : g_hi0
				assign hi = '0;
			end else begin : g_hi
				assign hi = cell_data[g+1];
			end

			always_comb begin
				cell_op[g] = OP_HOLD;
				if (state_q == S_UPD) begin
					case (kind_q)
						UPD_INSERT: begin
							if (G_IDX == tgt_q)
								cell_op[g] = OP_LOAD;
							else if (G_IDX > tgt_q)
								cell_op[g] = OP_UP;
						end
						UPD_DELETE: begin
							if (G_IDX >= tgt_q)
								cell_op[g] = OP_DOWN;
						end
						default: cell_op[g] = OP_HOLD;
					endcase
				end
			end

			slist_cell #(
				.DATA_WIDTH(DATA_WIDTH),
				.PW        (PW),
				.INDEX     (g)
			) u_cell (
				.clk    (clk),
				.cmp_en (state_q == S_CMP),
				.key    (key),
				.count  (count_q),
				.rd_pos (rd_pos),
				.op     (cell_op[g]),
				.lo_data(lo),
				.hi_data(hi),
				.data   (cell_data[g]),
				.match  (cell_match[g]),
				.rd_word(cell_rd[g])
			);
		end
	endgenerate

	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		rd_any  = '0;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			rd_any = rd_any | cell_rd[i];
			if (cell_match[i]) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
	end

	assign hit_pos = PW'(hit_idx);

	always_comb begin
		nxt_count               = count_q;
		nxt_tgt                 = pos;
		nxt_kind                = UPD_NONE;
		nxt_rsp.result_value    = '0;
		nxt_rsp.result_position = '0;
		nxt_rsp.status          = ST_OK;
		case (action_t'(req_q.action))
			ACT_PUSH: begin
				if (count_q == FULL_CNT) begin
					nxt_rsp.status = ST_FULL;
				end else begin
					nxt_tgt   = count_q;
					nxt_kind  = UPD_INSERT;
					nxt_count = count_q + PW'(1);
				end
			end
			ACT_POP: begin
				if (count_q == '0) begin
					nxt_rsp.status = ST_MISS;
				end else begin
					nxt_count            = count_q - PW'(1);
					nxt_rsp.result_value = 32'(rd_any);
				end
			end
			ACT_READ: begin
				if (pos >= count_q)
					nxt_rsp.status = ST_MISS;
				else
					nxt_rsp.result_value = 32'(rd_any);
			end
			ACT_INSERT: begin
				if (pos > count_q) begin
					nxt_rsp.status = ST_MISS;
				end else if (count_q == FULL_CNT) begin
					nxt_rsp.status = ST_FULL;
				end else begin
					nxt_kind  = UPD_INSERT;
					nxt_count = count_q + PW'(1);
				end
			end
			ACT_DELETE: begin
				if (pos >= count_q) begin
					nxt_rsp.status = ST_MISS;
				end else begin
					nxt_kind  = UPD_DELETE;
					nxt_count = count_q - PW'(1);
				end
			end
			ACT_REMOVE: begin
				if (hit) begin
					nxt_rsp.result_position = 6'(hit_idx);
					nxt_tgt                 = hit_pos;
					nxt_kind                = UPD_DELETE;
					nxt_count               = count_q - PW'(1);
				end else begin
					nxt_rsp.status = ST_MISS;
				end
			end
			ACT_FIND: begin
				if (hit)
					nxt_rsp.result_position = 6'(hit_idx);
				else
					nxt_rsp.status = ST_MISS;
			end
			default: nxt_rsp.status = ST_MISS;
		endcase
		nxt_rsp.entry_count = 7'(nxt_count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			kind_q  <= UPD_NONE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					kind_q <= UPD_NONE;
					if (start) begin
						req_q   <= req;
						state_q <= S_CMP;
					end
				end
				S_CMP: state_q <= S_RES;
				S_RES: begin
					count_q <= nxt_count;
					tgt_q   <= nxt_tgt;
					kind_q  <= nxt_kind;
					rsp_q   <= nxt_rsp;
					done_q  <= 1'b1;
					state_q <= S_UPD;
				end
				S_UPD: begin
					kind_q  <= UPD_NONE;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = rsp_q;

	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result word not delivered three cycles after accept");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above capacity");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status == ST_FULL)) |-> (count_q == FULL_CNT))
		else $error("full status on a list that is not full");

	a_done_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result word outside a request");

endmodule

// File: test/shifting_ordered_list_tb.sv
`timescale 1ns / 1ps

module shifting_ordered_list_tb;
	import slist_pkg::*;

	localparam int DEPTH = 64;
	localparam int DATA_WIDTH = 32;
	localparam logic [2:0] ACT_UNUSED = 3'd7;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_WORDS = 440;
	localparam int PHASE_WORDS = 80;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic done;
	rsp_t result;

	logic [DATA_WIDTH-1:0] list_words [DEPTH];
	int list_len = 0;
	rsp_t awaited_results [$];
	int err_count = 0;
	int idle_cycles = 0;
	bit no_gaps = 1'b0;
	logic [31:0] value_pool [8];

	shifting_ordered_list #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.result(result)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic rsp_t list_response(input req_t w);
		rsp_t r;
		logic [DATA_WIDTH-1:0] v;
		int hit;
		int drop_pos;
		int i;
		r = '0;
		v = w.item_value[DATA_WIDTH-1:0];
		hit = -1;
		drop_pos = -1;
		for (i = list_len - 1; i >= 0; i--)
			if (list_words[i] == v)
				hit = i;
		case (w.action)
			ACT_PUSH: begin
				if (list_len >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					list_words[list_len] = v;
					list_len++;
				end
			end
			ACT_POP: begin
				if (list_len == 0) begin
					r.status = ST_MISS;
				end else begin
					list_len--;
					r.result_value = list_words[list_len];
				end
			end
			ACT_READ: begin
				if (w.position >= list_len)
					r.status = ST_MISS;
				else
					r.result_value = list_words[w.position];
			end
			ACT_INSERT: begin
				if (w.position > list_len) begin
					r.status = ST_MISS;
				end else if (list_len >= DEPTH) begin
					r.status = ST_FULL;
				end else begin
					for (i = list_len; i > w.position; i--)
						list_words[i] = list_words[i-1];
					list_words[w.position] = v;
					list_len++;
				end
			end
			ACT_DELETE: begin
				if (w.position >= list_len)
					r.status = ST_MISS;
				else
					drop_pos = w.position;
			end
			ACT_REMOVE: begin
				if (hit >= 0) begin
					r.result_position = hit[5:0];
					drop_pos = hit;
				end else begin
					r.status = ST_MISS;
				end
			end
			ACT_FIND: begin
				if (hit >= 0)
					r.result_position = hit[5:0];
				else
					r.status = ST_MISS;
			end
			default: r.status = ST_MISS;
		endcase
		if (drop_pos >= 0) begin
			for (i = drop_pos; i + 1 < list_len; i++)
				list_words[i] = list_words[i+1];
			list_len--;
		end
		r.entry_count = list_len[6:0];
		return r;
	endfunction

	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	task automatic send_word(input logic [2:0] act, input logic [6:0] pos,
			input logic [31:0] val);
		int gap;
		gap = no_gaps ? 0 : gap_cycles();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		req <= '{action: act, position: pos, item_value: val};
		do @(posedge clk); while (busy);
		awaited_results.push_back(list_response('{action: act, position: pos, item_value: val}));
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		rsp_t exp_r;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				$error("result word %h with nothing awaited", result);
				err_count++;
			end else begin
				exp_r = awaited_results.pop_front();
				if (result.result_value !== exp_r.result_value) begin
					$error("result_value: expected %h, got %h",
						exp_r.result_value, result.result_value);
					err_count++;
				end
				if (result.result_position !== exp_r.result_position) begin
					$error("result_position: expected %0d, got %0d",
						exp_r.result_position, result.result_position);
					err_count++;
				end
				if (result.entry_count !== exp_r.entry_count) begin
					$error("entry_count: expected %0d, got %0d",
						exp_r.entry_count, result.entry_count);
					err_count++;
				end
				if (result.status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, result.status);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic test_empty_list();
		send_word(ACT_POP, 7'd0, 32'h0);
		send_word(ACT_READ, 7'd0, 32'h0);
		send_word(ACT_READ, 7'd127, 32'hFFFF_FFFF);
		send_word(ACT_DELETE, 7'd0, 32'h0);
		send_word(ACT_REMOVE, 7'd0, value_pool[0]);
		send_word(ACT_FIND, 7'd0, value_pool[0]);
		send_word(ACT_INSERT, 7'd1, 32'h1234_5678);
		send_word(ACT_UNUSED, 7'd127, 32'hFFFF_FFFF);
		send_word(ACT_INSERT, 7'd0, 32'h1234_5678);
		send_word(ACT_POP, 7'd0, 32'h0);
	endtask

	task automatic test_list_ops();
		send_word(ACT_PUSH, 7'd0, 32'hFFFF_FFFF);
		send_word(ACT_PUSH, 7'd127, 32'h0000_0000);
		send_word(ACT_PUSH, 7'd0, 32'hA5A5_A5A5);
		send_word(ACT_INSERT, 7'd1, 32'h5A5A_5A5A);
		send_word(ACT_INSERT, 7'd4, 32'h8000_0001);
		send_word(ACT_READ, 7'd0, 32'h0);
		send_word(ACT_READ, 7'd4, 32'h0);
		send_word(ACT_READ, 7'd5, 32'h0);
		send_word(ACT_PUSH, 7'd0, 32'hFFFF_FFFF);
		send_word(ACT_FIND, 7'd0, 32'hFFFF_FFFF);
		send_word(ACT_REMOVE, 7'd0, 32'hFFFF_FFFF);
		send_word(ACT_FIND, 7'd0, 32'hFFFF_FFFF);
		send_word(ACT_DELETE, 7'd1, 32'h0);
		send_word(ACT_DELETE, 7'd4, 32'h0);
		send_word(ACT_FIND, 7'd0, 32'hDEAD_BEEF);
		send_word(ACT_REMOVE, 7'd0, 32'hDEAD_BEEF);
		send_word(ACT_UNUSED, 7'd2, 32'h0);
		while (list_len > 0)
			send_word(ACT_POP, 7'd0, 32'h0);
	endtask

	task automatic test_full_list();
		logic [31:0] tail_word;
		while (list_len < DEPTH - 1)
			send_word(ACT_PUSH, 7'($urandom_range(0, 127)), $urandom);
		tail_word = $urandom;
		send_word(ACT_INSERT, 7'd63, tail_word);
		send_word(ACT_PUSH, 7'd0, 32'h0);
		send_word(ACT_INSERT, 7'd0, 32'h0);
		send_word(ACT_INSERT, 7'd64, 32'h0);
		send_word(ACT_INSERT, 7'd100, 32'h0);
		send_word(ACT_READ, 7'd63, 32'h0);
		send_word(ACT_READ, 7'd64, 32'h0);
		send_word(ACT_FIND, 7'd0, tail_word);
		send_word(ACT_REMOVE, 7'd0, tail_word);
		send_word(ACT_DELETE, 7'd0, 32'h0);
		send_word(ACT_INSERT, 7'd0, 32'hFFFF_FFFF);
		send_word(ACT_PUSH, 7'd0, 32'h0);
		send_word(ACT_PUSH, 7'd0, 32'h0);
	endtask

	task automatic test_random_traffic();
		logic [2:0] act;
		logic [6:0] pos;
		logic [31:0] val;
		bit grow;
		int r;
		grow = 1'b0;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % PHASE_WORDS == 0) begin
				grow = (list_len < DEPTH / 2) ? ($urandom_range(0, 3) != 0)
					: ($urandom_range(0, 3) == 0);
				no_gaps = ($urandom_range(0, 3) == 0);
			end
			r = $urandom_range(0, 99);
			if (r < 5) begin
				act = 3'($urandom_range(0, 7));
				pos = 7'($urandom_range(0, 127));
				val = $urandom;
			end else begin
				r = $urandom_range(0, 99);
				if (grow)
					act = (r < 25) ? ACT_PUSH : (r < 50) ? ACT_INSERT : (r < 58) ? ACT_POP
						: (r < 66) ? ACT_DELETE : (r < 80) ? ACT_READ
						: (r < 90) ? ACT_FIND : ACT_REMOVE;
				else
					act = (r < 8) ? ACT_PUSH : (r < 16) ? ACT_INSERT : (r < 41) ? ACT_POP
						: (r < 66) ? ACT_DELETE : (r < 80) ? ACT_READ
						: (r < 90) ? ACT_FIND : ACT_REMOVE;
				if ($urandom_range(0, 9) == 0)
					pos = 7'($urandom_range(0, 127));
				else if (act == ACT_INSERT)
					pos = 7'($urandom_range(0, list_len));
				else if (list_len > 0)
					pos = 7'($urandom_range(0, list_len - 1));
				else
					pos = 7'd0;
				val = ($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, 7)] : $urandom;
			end
			send_word(act, pos, val);
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		value_pool[0] = 32'h0000_0000;
		value_pool[1] = 32'hFFFF_FFFF;
		value_pool[2] = 32'h8000_0000;
		value_pool[3] = 32'h0000_0001;
		for (int i = 4; i < 8; i++)
			value_pool[i] = $urandom;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_empty_list();
		test_list_ops();
		test_full_list();
		test_random_traffic();
		start <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
